/* hdl/directory_entry_insertion_sort_top_macros.svh */
// assertion macros for the sorter controller
`ifndef DIRECTORY_ENTRY_INSERTION_SORT_TOP_MACROS_SVH
`define DIRECTORY_ENTRY_INSERTION_SORT_TOP_MACROS_SVH

// same-cycle implication, checked on every rising edge outside reset
`define DESORT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DESORT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/desort_pkg.sv */
// types, constants and name key function for the directory entry sorter
package desort_pkg;

  localparam int DefaultMaxEntries = 32;
  localparam int NameBytes         = 14;
  localparam int KeyW              = 8 * NameBytes;

  typedef struct packed {
    logic [15:0] entry_inode;
    logic [63:0] name_head;
    logic [47:0] name_tail;
    logic        final_entry;
  } entry_in_t;

  typedef struct packed {
    logic [15:0] sorted_inode;
    logic [63:0] sorted_name_head;
    logic [47:0] sorted_name_tail;
    logic        run_end;
    logic        overflowed;
  } result_t;

  // one stored entry, 128 bits
  typedef struct packed {
    logic [15:0] inode;
    logic [63:0] head;
    logic [47:0] tail;
  } slot_t;

  // zero every byte after the first zero byte, so a plain unsigned compare
  // of the keys gives the terminated string order
  function automatic logic [KeyW-1:0] name_key(logic [63:0] head, logic [47:0] tail);
    logic [KeyW-1:0] raw;
    logic [KeyW-1:0] key;
    logic            ended;
    raw   = {head, tail};
    key   = '0;
    ended = 1'b0;
    for (int i = 0; i < NameBytes; i++) begin
      if (!ended) begin
        key[KeyW-1-8*i -: 8] = raw[KeyW-1-8*i -: 8];
      end
      if (raw[KeyW-1-8*i -: 8] == 8'h00) begin
        ended = 1'b1;
      end
    end
    return key;
  endfunction

endpackage

/* hdl/directory_entry_insertion_sort_top.sv */
// directory entry sorter: stable insertion into a memory, sorted run on the final entry
//
//   channel   handshake              payload            direction
//   entry     start_i / busy_o       entry_i            in
//   result    result_valid_o strobe  result_o           out
//
// an entry walks down from the last stored entry; each stored entry that compares greater moves up
//   one slot in turn through the single memory write port; an entry into an empty store is written directly
// a final entry then emits every stored entry, one per cycle
// a dropped entry (store full) is not written; busy_o is high while inserting or emitting
// reset empties the store and clears the overflow flag; the receiver cannot stall results
module directory_entry_insertion_sort_top import desort_pkg::*; #(
  parameter int MaxEntries = DefaultMaxEntries
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  entry_in_t entry_i,
  output logic      busy_o,
  output logic      result_valid_o,
  output result_t   result_o
);

  localparam int AddrW = $clog2(MaxEntries);
  localparam int CntW  = $clog2(MaxEntries + 1);

  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  slot_t            mem_wdata;
  logic             mem_re;
  logic [AddrW-1:0] mem_raddr;
  slot_t            mem_rdata;
  logic             out_last;
  logic             out_ovf;

  desort_ctrl #(
    .MaxEntries (MaxEntries),
    .AddrW      (AddrW),
    .CntW       (CntW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .entry_i     (entry_i),
    .busy_o      (busy_o),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata),
    .out_valid_o (result_valid_o),
    .out_last_o  (out_last),
    .out_ovf_o   (out_ovf)
  );

  desort_store #(
    .MaxEntries (MaxEntries),
    .AddrW      (AddrW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign result_o.sorted_inode     = mem_rdata.inode;
  assign result_o.sorted_name_head = mem_rdata.head;
  assign result_o.sorted_name_tail = mem_rdata.tail;
  assign result_o.run_end          = out_last;
  assign result_o.overflowed       = out_ovf;

endmodule

/* hdl/desort_store.sv */
// entry memory: one write port, one read port with registered read data
module desort_store import desort_pkg::*; #(
  parameter int MaxEntries = DefaultMaxEntries,
  parameter int AddrW      = $clog2(MaxEntries)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  slot_t            wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output slot_t            rdata_o
);

  slot_t mem [MaxEntries];
  slot_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/desort_ctrl.sv */
// insertion and emission sequencer around the entry memory
`include "directory_entry_insertion_sort_top_macros.svh"

module desort_ctrl import desort_pkg::*; #(
  parameter int MaxEntries = DefaultMaxEntries,
  parameter int AddrW      = $clog2(MaxEntries),
  parameter int CntW       = $clog2(MaxEntries + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  entry_in_t        entry_i,
  output logic             busy_o,
  output logic             mem_we_o,
  output logic [AddrW-1:0] mem_waddr_o,
  output slot_t            mem_wdata_o,
  output logic             mem_re_o,
  output logic [AddrW-1:0] mem_raddr_o,
  input  slot_t            mem_rdata_i,
  output logic             out_valid_o,
  output logic             out_last_o,
  output logic             out_ovf_o
);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StScan  = 2'd1;
  localparam logic [1:0] StPlace = 2'd2;
  localparam logic [1:0] StEmit  = 2'd3;

  logic [1:0]      state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic            ovf_q, ovf_d;
  logic [AddrW-1:0] j_q, j_d;
  logic [AddrW-1:0] e_q, e_d;
  slot_t           new_q, new_d;
  logic [KeyW-1:0] key_q, key_d;
  logic            final_q, final_d;
  logic            out_vld_q, out_vld_d;
  logic            out_last_q, out_last_d;
  logic            out_ovf_q, out_ovf_d;

  logic            accept;
  logic            full;
  logic            stored_gt;
  logic            emit_last;

  assign accept    = start_i && (state_q == StIdle);
  assign full      = (count_q == CntW'(MaxEntries));
  assign stored_gt = name_key(mem_rdata_i.head, mem_rdata_i.tail) > key_q;
  assign emit_last = ((CntW'(e_q) + CntW'(1)) == count_q);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    ovf_d       = ovf_q;
    j_d         = j_q;
    e_d         = e_q;
    new_d       = new_q;
    key_d       = key_q;
    final_d     = final_q;
    out_vld_d   = 1'b0;
    out_last_d  = 1'b0;
    out_ovf_d   = out_ovf_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = '0;
    mem_wdata_o = new_q;
    mem_re_o    = 1'b0;
    mem_raddr_o = '0;

    case (state_q)
      StIdle: begin
        if (accept) begin
          new_d.inode = entry_i.entry_inode;
          new_d.head  = entry_i.name_head;
          new_d.tail  = entry_i.name_tail;
          key_d       = name_key(entry_i.name_head, entry_i.name_tail);
          final_d     = entry_i.final_entry;
          e_d         = '0;
          if (full) begin
            ovf_d = 1'b1;
            if (entry_i.final_entry) begin
              state_d = StEmit;
            end
          end else if (count_q == '0) begin
            mem_we_o    = 1'b1;
            mem_waddr_o = '0;
            mem_wdata_o = new_d;
            count_d     = CntW'(1);
            if (entry_i.final_entry) begin
              state_d = StEmit;
            end
          end else begin
            // walk down from the last stored entry
            mem_re_o    = 1'b1;
            mem_raddr_o = AddrW'(count_q - CntW'(1));
            j_d         = AddrW'(count_q - CntW'(1));
            state_d     = StScan;
          end
        end
      end
      StScan: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = j_q + AddrW'(1);
        if (stored_gt) begin
          // move the greater entry up one slot
          mem_wdata_o = mem_rdata_i;
          if (j_q == '0) begin
            state_d = StPlace;
          end else begin
            mem_re_o    = 1'b1;
            mem_raddr_o = j_q - AddrW'(1);
            j_d         = j_q - AddrW'(1);
          end
        end else begin
          mem_wdata_o = new_q;
          count_d     = count_q + CntW'(1);
          state_d     = final_q ? StEmit : StIdle;
        end
      end
      StPlace: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = '0;
        mem_wdata_o = new_q;
        count_d     = count_q + CntW'(1);
        state_d     = final_q ? StEmit : StIdle;
      end
      StEmit: begin
        mem_re_o    = 1'b1;
        mem_raddr_o = e_q;
        out_vld_d   = 1'b1;
        out_last_d  = emit_last;
        out_ovf_d   = ovf_q;
        if (emit_last) begin
          count_d = '0;
          ovf_d   = 1'b0;
          state_d = StIdle;
        end else begin
          e_d = e_q + AddrW'(1);
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      count_q    <= '0;
      ovf_q      <= 1'b0;
      j_q        <= '0;
      e_q        <= '0;
      out_vld_q  <= 1'b0;
      out_last_q <= 1'b0;
      out_ovf_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      ovf_q      <= ovf_d;
      j_q        <= j_d;
      e_q        <= e_d;
      out_vld_q  <= out_vld_d;
      out_last_q <= out_last_d;
      out_ovf_q  <= out_ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    new_q   <= new_d;
    key_q   <= key_d;
    final_q <= final_d;
  end

  assign busy_o      = (state_q != StIdle);
  assign out_valid_o = out_vld_q;
  assign out_last_o  = out_last_q;
  assign out_ovf_o   = out_ovf_q;

  `DESORT_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CntW'(MaxEntries), "entry count beyond capacity")
  `DESORT_ASSERT_NOW(a_port_conflict, mem_we_o && mem_re_o, mem_waddr_o != mem_raddr_o, "read and write hit one entry")
  `DESORT_ASSERT_NOW(a_result_from_emit, out_vld_q, $past(state_q) == StEmit, "result strobe outside emission")
  `DESORT_ASSERT_NEXT(a_full_drop, accept && full, !mem_we_o && count_q == CntW'(MaxEntries), "dropped entry was written")
  `DESORT_ASSERT_NEXT(a_run_clears, out_vld_d && out_last_d, count_q == '0 && !ovf_q, "store not emptied after run")

endmodule
